// ===== src/kdio_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package kdio_pkg;

   // Bus operation codes.
   localparam logic [1:0] FUNC_READ  = 2'd0;
   localparam logic [1:0] FUNC_WRITE = 2'd1;
   localparam logic [1:0] FUNC_KEY   = 2'd2;

   // Port addresses in the I/O window.
   localparam logic [15:0] PORT_KEY_DATA   = 16'hD010;
   localparam logic [15:0] PORT_KEY_STATUS = 16'hD011;
   localparam logic [15:0] PORT_DSP_DATA   = 16'hD012;
   localparam logic [15:0] PORT_DSP_STATUS = 16'hD013;

   // Character codes.
   localparam logic [6:0] CHAR_BS    = 7'h08;
   localparam logic [6:0] CHAR_LF    = 7'h0A;
   localparam logic [6:0] CHAR_CR    = 7'h0D;
   localparam logic [6:0] CHAR_DEL   = 7'h7F;
   localparam logic [6:0] CHAR_SPACE = 7'h20;
   localparam logic [6:0] CHAR_TILDE = 7'h7E;
   localparam logic [7:0] KEY_LF     = 8'h0A;
   localparam logic [7:0] KEY_CR     = 8'h0D;
   localparam logic [7:0] KEY_LOW_A  = 8'h61;
   localparam logic [7:0] KEY_LOW_Z  = 8'h7A;
   localparam logic [7:0] CASE_SHIFT = 8'h20;
   localparam logic [7:0] READ_FLAG  = 8'h80;

   localparam int STORE_DEPTH_DEFAULT = 65536;

   typedef struct packed {
      logic [1:0]  func;
      logic [15:0] address;
      logic [7:0]  write_data;
      logic [7:0]  key_code;
   } req_word_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       display_valid;
      logic [6:0] display_char;
   } rsp_word_type;

   typedef struct packed {
      logic       valid;
      logic [6:0] char;
   } dsp_char_type;

   // Maps a byte written to the display port onto a display character.
   function automatic dsp_char_type display_map(input logic [7:0] value);
      logic [6:0]   c;
      dsp_char_type res;
      c         = value[6:0];
      res.valid = 1'b0;
      res.char  = '0;
      if (c == CHAR_DEL) begin
         res.valid = 1'b1;
         res.char  = CHAR_BS;
      end else if (c == CHAR_LF || c == CHAR_CR) begin
         res.valid = 1'b1;
         res.char  = CHAR_LF;
      end else if (c >= CHAR_SPACE && c <= CHAR_TILDE) begin
         res.valid = 1'b1;
         res.char  = c;
      end
      return res;
   endfunction

   // Line feed becomes carriage return, lower case folds to upper case.
   function automatic logic [6:0] key_map(input logic [7:0] code);
      logic [7:0] k;
      k = code;
      if (code == KEY_LF) begin
         k = KEY_CR;
      end else if (code >= KEY_LOW_A && code <= KEY_LOW_Z) begin
         k = code - CASE_SHIFT;
      end
      return k[6:0];
   endfunction

endpackage

`default_nettype wire

// ===== src/keyboard_display_io_bus.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake             Word
// req_      in         req_valid/req_ready   kdio_pkg::req_word_type
// rsp_      out        rsp_valid/rsp_ready   kdio_pkg::rsp_word_type
//
// Every accepted word gives exactly one result word, through the middle stage
// and the result register; a new word can be accepted on every clock while
// the middle stage is not held.
// Reset clears the key flag, the key latch and all pipeline valid bits; the
// byte store is not cleared and entries read before a write are undefined.
// When the result register is full and not taken, the middle stage holds and
// req_ready drops, so the store read data register keeps its value.
// STORE_DEPTH must be a power of two; the store index is the low address bits.
module keyboard_display_io_bus #(
   parameter int STORE_DEPTH = kdio_pkg::STORE_DEPTH_DEFAULT
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  kdio_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output kdio_pkg::rsp_word_type rsp_word
);

   localparam int IDX_W = $clog2(STORE_DEPTH);

   // Byte store, one write or one read per cycle.
   logic [7:0] store [STORE_DEPTH];
   logic [7:0] mem_q_ff;

   // Key port state.
   logic       key_ready_ff, key_ready_in;
   logic [6:0] key_latch_ff, key_latch_in;

   // Middle stage: result with port data, plus a select for store data.
   logic                   s1_valid_ff, s1_valid_in;
   logic                   s1_mem_sel_ff, s1_mem_sel_in;
   kdio_pkg::rsp_word_type s1_word_ff, s1_word_in;

   // Result register.
   logic                   out_valid_ff, out_valid_in;
   kdio_pkg::rsp_word_type out_word_ff, out_word_in;

   logic                   req_accept;
   logic                   s1_advance;
   logic                   is_port;
   logic                   mem_we;
   logic                   mem_re;
   logic [IDX_W-1:0]       mem_idx;
   kdio_pkg::dsp_char_type dsp;

   assign s1_advance = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign req_accept = req_valid && req_ready;

   // The four port addresses share the top 14 bits.
   assign is_port = (req_word.address == kdio_pkg::PORT_KEY_DATA)
                 || (req_word.address == kdio_pkg::PORT_KEY_STATUS)
                 || (req_word.address == kdio_pkg::PORT_DSP_DATA)
                 || (req_word.address == kdio_pkg::PORT_DSP_STATUS);

   assign mem_idx = req_word.address[IDX_W-1:0];
   assign mem_we  = req_accept && (req_word.func == kdio_pkg::FUNC_WRITE)
                 && (req_word.address != kdio_pkg::PORT_DSP_DATA);
   assign mem_re  = req_accept && (req_word.func == kdio_pkg::FUNC_READ) && !is_port;
   assign dsp     = kdio_pkg::display_map(req_word.write_data);

   // A write lands in the store in its own accept cycle, so any later read of
   // the same entry is issued in a later cycle and sees the data.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store[mem_idx] <= req_word.write_data;
      end
      if (mem_re) begin
         mem_q_ff <= store[mem_idx];
      end
   end

   // Decode of the accepted word: port reads, key events and display writes
   // are settled here; store reads take their data from the store read data register.
   always_comb begin
      key_ready_in  = key_ready_ff;
      key_latch_in  = key_latch_ff;
      s1_valid_in   = s1_valid_ff && !s1_advance;
      s1_mem_sel_in = s1_mem_sel_ff;
      s1_word_in    = s1_word_ff;
      if (req_accept) begin
         s1_valid_in   = 1'b1;
         s1_mem_sel_in = 1'b0;
         s1_word_in    = '0;
         unique case (req_word.func)
            kdio_pkg::FUNC_READ: begin
               if (req_word.address == kdio_pkg::PORT_KEY_DATA) begin
                  if (key_ready_ff) begin
                     s1_word_in.read_data = kdio_pkg::READ_FLAG | {1'b0, key_latch_ff};
                     key_ready_in         = 1'b0;
                  end
               end else if (req_word.address == kdio_pkg::PORT_KEY_STATUS) begin
                  s1_word_in.read_data = key_ready_ff ? kdio_pkg::READ_FLAG : 8'h00;
               end else if (!is_port) begin
                  s1_mem_sel_in = 1'b1;
               end
            end
            kdio_pkg::FUNC_WRITE: begin
               if (req_word.address == kdio_pkg::PORT_DSP_DATA) begin
                  s1_word_in.display_valid = dsp.valid;
                  s1_word_in.display_char  = dsp.char;
               end
            end
            kdio_pkg::FUNC_KEY: begin
               key_latch_in = kdio_pkg::key_map(req_word.key_code);
               key_ready_in = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      out_word_in  = out_word_ff;
      if (s1_advance) begin
         out_valid_in = 1'b1;
         out_word_in  = s1_word_ff;
         if (s1_mem_sel_ff) begin
            out_word_in.read_data = mem_q_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ready_ff <= 1'b0;
         key_latch_ff <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         key_ready_ff <= key_ready_in;
         key_latch_ff <= key_latch_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_mem_sel_ff <= s1_mem_sel_in;
      s1_word_ff    <= s1_word_in;
      out_word_ff   <= out_word_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

   // A key read always leaves the flag cleared.
   assert property (@(posedge clock) disable iff (reset)
      req_accept && req_word.func == kdio_pkg::FUNC_READ
      && req_word.address == kdio_pkg::PORT_KEY_DATA |=> !key_ready_ff)
      else $error("key flag still set after key data read");

   // A key event always leaves the flag set. A code with bit 7 set is not
   // folded, so the latch may still hold a lower case letter.
   assert property (@(posedge clock) disable iff (reset)
      req_accept && req_word.func == kdio_pkg::FUNC_KEY |=> key_ready_ff)
      else $error("key event not latched correctly");

   // Display characters are only backspace, newline or printable.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.display_valid
      |-> rsp_word.display_char == kdio_pkg::CHAR_BS
       || rsp_word.display_char == kdio_pkg::CHAR_LF
       || (rsp_word.display_char >= kdio_pkg::CHAR_SPACE
           && rsp_word.display_char <= kdio_pkg::CHAR_TILDE))
      else $error("illegal display character");

   // A held middle stage must block new words, or store data would be lost.
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_advance |-> !req_accept)
      else $error("word accepted while middle stage stalled");

endmodule

`default_nettype wire
